@@ hw/rtl/led_pattern_controller_top_defines.svh @@
// Assertion macros used by the LED pattern controller mode engine.
`ifndef LED_PATTERN_CONTROLLER_TOP_DEFINES_SVH
`define LED_PATTERN_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/lpc_pkg.sv @@
// Package with the types, codes and constants of the LED pattern controller.
package lpc_pkg;

   localparam int OP_W         = 4;
   localparam int STEP_W       = 8;
   localparam int DUTY_W       = 8;
   localparam int MS_W         = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int BRIGHT_W     = 8;

   localparam int PULSE_INCREMENT_DEF = 8;
   localparam int PULSE_TOP_DEF       = 100;
   localparam int PULSE_PAUSE_MS_DEF  = 200;

   localparam logic [MS_W-1:0] DEFAULT_PERIOD_RST = 16'd300;
   localparam logic [MS_W-1:0] SLOW_PERIOD_RST    = 16'd1000;
   localparam logic [MS_W-1:0] FAST_PERIOD_RST    = 16'd100;
   localparam logic [MS_W-1:0] ELAPSED_MAX        = 16'hFFFF;
   localparam logic [DUTY_W-1:0] DUTY_FULL        = 8'd255;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 4'd0,
      OP_ON    = 4'd1,
      OP_OFF   = 4'd2,
      OP_FLASH = 4'd3,
      OP_DIP   = 4'd4,
      OP_BLINK = 4'd5,
      OP_PULSE = 4'd6,
      OP_SLOW  = 4'd7,
      OP_FAST  = 4'd8
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEFAULT_PERIOD = 2'd0,
      CSR_SLOW_PERIOD    = 2'd1,
      CSR_FAST_PERIOD    = 2'd2
   } csr_index_type;

   typedef enum logic [6:0] {
      MODE_OFF        = 7'b0000001,
      MODE_ON         = 7'b0000010,
      MODE_FLASH      = 7'b0000100,
      MODE_DIP        = 7'b0001000,
      MODE_BLINK_LIT  = 7'b0010000,
      MODE_BLINK_DARK = 7'b0100000,
      MODE_PULSE      = 7'b1000000
   } mode_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [STEP_W-1:0] blink_lit_step;
      logic [STEP_W-1:0] blink_cycle_steps;
   } req_word_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              led_on;
   } rsp_word_type;

   typedef struct packed {
      logic advance;
   } flow_type;

endpackage

@@ hw/rtl/led_pattern_controller_top.sv @@
// Top level of the LED pattern controller.
// Each request word is either a millisecond tick or a command and produces exactly one
// response word with the PWM duty and the pin level. The block accepts one word per clock
// cycle when the response side does not stall; a word waits in the input register, where the
// mode machine computes its new state in one pass, and is then registered into the response
// register. The user must write the period registers through the csr_ port only while no
// words are in flight; the block itself does not enforce this.
module led_pattern_controller_top
   import lpc_pkg::*;
#(
   parameter int PULSE_INCREMENT = PULSE_INCREMENT_DEF,
   parameter int PULSE_TOP       = PULSE_TOP_DEF,
   parameter int PULSE_PAUSE_MS  = PULSE_PAUSE_MS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [STEP_W-1:0]      req_blink_lit_step,
   input  logic [STEP_W-1:0]      req_blink_cycle_steps,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [DUTY_W-1:0]      rsp_duty,
   output logic                   rsp_led_on
);

   flow_type     flow;
   req_word_type word;
   rsp_word_type result;
   logic         rsp_ready;

   lpc_req_stage u_req_stage (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_blink_lit_step    (req_blink_lit_step),
      .req_blink_cycle_steps (req_blink_cycle_steps),
      .rsp_ready             (rsp_ready),
      .flow                  (flow),
      .word                  (word)
   );

   lpc_mode_engine #(
      .PULSE_INCREMENT (PULSE_INCREMENT),
      .PULSE_TOP       (PULSE_TOP),
      .PULSE_PAUSE_MS  (PULSE_PAUSE_MS)
   ) u_mode_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .flow      (flow),
      .word      (word),
      .result    (result)
   );

   lpc_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .flow       (flow),
      .result     (result),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_duty   (rsp_duty),
      .rsp_led_on (rsp_led_on)
   );

endmodule

@@ hw/rtl/lpc_req_stage.sv @@
// Input register stage of the LED pattern controller.
module lpc_req_stage
   import lpc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [STEP_W-1:0]   req_blink_lit_step,
   input  logic [STEP_W-1:0]   req_blink_cycle_steps,
   input  logic                rsp_ready,
   output flow_type            flow,
   output req_word_type        word
);

   logic         in_valid_ff;
   logic         in_valid_in;
   req_word_type word_ff;
   logic         advance;
   logic         load;

   assign advance   = in_valid_ff && rsp_ready;
   assign req_stall = in_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (load) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff.operation         <= req_operation;
         word_ff.blink_lit_step    <= req_blink_lit_step;
         word_ff.blink_cycle_steps <= req_blink_cycle_steps;
      end
   end

   assign flow.advance   = advance;
   assign word           = word_ff;

endmodule

@@ hw/rtl/lpc_mode_engine.sv @@
// Mode state, configuration registers and per-word update logic.
module lpc_mode_engine
   import lpc_pkg::*;
#(
   parameter int PULSE_INCREMENT = PULSE_INCREMENT_DEF,
   parameter int PULSE_TOP       = PULSE_TOP_DEF,
   parameter int PULSE_PAUSE_MS  = PULSE_PAUSE_MS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  flow_type               flow,
   input  req_word_type           word,
   output rsp_word_type           result
);

   `include "led_pattern_controller_top_defines.svh"

   logic [MS_W-1:0]     default_period_ff;
   logic [MS_W-1:0]     slow_period_ff;
   logic [MS_W-1:0]     fast_period_ff;

   mode_type            mode_ff, mode_in;
   logic [MS_W-1:0]     elapsed_ff, elapsed_in;
   logic [MS_W-1:0]     period_ff, period_in;
   logic [STEP_W-1:0]   blink_step_ff, blink_step_in;
   logic [STEP_W-1:0]   lit_step_ff, lit_step_in;
   logic [STEP_W-1:0]   cycle_steps_ff, cycle_steps_in;
   logic [BRIGHT_W-1:0] bright_ff, bright_in;
   logic                falling_ff, falling_in;
   logic                pin_ff, pin_in;

   logic                run;
   logic                due;
   logic [STEP_W:0]     next_step;
   logic signed [BRIGHT_W+1:0] level;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_period_ff <= DEFAULT_PERIOD_RST;
         slow_period_ff    <= SLOW_PERIOD_RST;
         fast_period_ff    <= FAST_PERIOD_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DEFAULT_PERIOD: default_period_ff <= csr_data;
            CSR_SLOW_PERIOD:    slow_period_ff    <= csr_data;
            CSR_FAST_PERIOD:    fast_period_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      mode_in        = mode_ff;
      elapsed_in     = elapsed_ff;
      period_in      = period_ff;
      blink_step_in  = blink_step_ff;
      lit_step_in    = lit_step_ff;
      cycle_steps_in = cycle_steps_ff;
      bright_in      = bright_ff;
      falling_in     = falling_ff;
      pin_in         = pin_ff;
      run            = 1'b0;
      due            = 1'b0;
      next_step      = '0;
      level          = '0;

      case (word.operation)
         OP_TICK: begin
            if (elapsed_ff != ELAPSED_MAX) begin
               elapsed_in = elapsed_ff + 16'd1;
            end
            run = 1'b1;
         end
         OP_ON: begin
            mode_in = MODE_ON;
            run     = 1'b1;
         end
         OP_OFF: begin
            mode_in = MODE_OFF;
            run     = 1'b1;
         end
         OP_FLASH: begin
            pin_in     = 1'b1;
            mode_in    = MODE_FLASH;
            elapsed_in = '0;
            period_in  = default_period_ff;
            run        = 1'b1;
         end
         OP_DIP: begin
            pin_in     = 1'b0;
            mode_in    = MODE_DIP;
            elapsed_in = '0;
            period_in  = default_period_ff;
            run        = 1'b1;
         end
         OP_BLINK: begin
            lit_step_in    = word.blink_lit_step;
            cycle_steps_in = word.blink_cycle_steps;
            blink_step_in  = 8'd1;
            mode_in        = MODE_BLINK_LIT;
            period_in      = default_period_ff;
            elapsed_in     = '0;
            run            = 1'b1;
         end
         OP_PULSE: begin
            mode_in    = MODE_PULSE;
            bright_in  = '0;
            falling_in = 1'b0;
            period_in  = 16'd1;
            elapsed_in = '0;
         end
         OP_SLOW: begin
            period_in = slow_period_ff;
         end
         OP_FAST: begin
            period_in = fast_period_ff;
         end
         default: begin
         end
      endcase

      if (run) begin
         due = elapsed_in > period_in;
         unique case (mode_in)
            MODE_FLASH: begin
               if (due) begin
                  pin_in  = 1'b0;
                  mode_in = MODE_OFF;
               end
            end
            MODE_DIP: begin
               if (due) begin
                  pin_in  = 1'b1;
                  mode_in = MODE_ON;
               end
            end
            MODE_BLINK_LIT: begin
               if (blink_step_in == lit_step_in) begin
                  pin_in = 1'b1;
               end
               if (due) begin
                  pin_in     = 1'b0;
                  mode_in    = MODE_BLINK_DARK;
                  elapsed_in = '0;
               end
            end
            MODE_BLINK_DARK: begin
               if (due) begin
                  next_step  = {1'b0, blink_step_in} + 9'd1;
                  mode_in    = MODE_BLINK_LIT;
                  elapsed_in = '0;
                  if (next_step > {1'b0, cycle_steps_in}) begin
                     blink_step_in = 8'd1;
                  end else begin
                     blink_step_in = next_step[STEP_W-1:0];
                  end
               end
            end
            MODE_PULSE: begin
               if (due) begin
                  elapsed_in = '0;
                  period_in  = 16'd1;
                  if (falling_in) begin
                     level = $signed({2'b00, bright_in}) - $signed(10'(PULSE_INCREMENT));
                  end else begin
                     level = $signed({2'b00, bright_in}) + $signed(10'(PULSE_INCREMENT));
                  end
                  if (level <= 10'sd0) begin
                     period_in  = 16'(PULSE_PAUSE_MS);
                     bright_in  = '0;
                     falling_in = !falling_in;
                  end else if (level >= $signed(10'(PULSE_TOP))) begin
                     bright_in  = 8'(PULSE_TOP);
                     falling_in = !falling_in;
                  end else begin
                     bright_in = level[BRIGHT_W-1:0];
                  end
               end
            end
            MODE_ON: begin
               pin_in = 1'b1;
            end
            MODE_OFF: begin
               pin_in = 1'b0;
            end
            default: begin
               pin_in = 1'b0;
            end
         endcase
      end

      result.led_on = pin_in;
      result.duty   = (mode_in == MODE_PULSE) ? bright_in : (pin_in ? DUTY_FULL : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_OFF;
         elapsed_ff     <= '0;
         period_ff      <= '0;
         blink_step_ff  <= 8'd1;
         lit_step_ff    <= 8'd1;
         cycle_steps_ff <= 8'd1;
         bright_ff      <= '0;
         falling_ff     <= 1'b0;
         pin_ff         <= 1'b0;
      end else if (flow.advance) begin
         mode_ff        <= mode_in;
         elapsed_ff     <= elapsed_in;
         period_ff      <= period_in;
         blink_step_ff  <= blink_step_in;
         lit_step_ff    <= lit_step_in;
         cycle_steps_ff <= cycle_steps_in;
         bright_ff      <= bright_in;
         falling_ff     <= falling_in;
         pin_ff         <= pin_in;
      end
   end

   `LPC_ASSERT_NEXT(a_pulse_start, clock, reset,
      flow.advance && (word.operation == OP_PULSE),
      (mode_ff == MODE_PULSE) && (bright_ff == '0) && !falling_ff,
      "Pulse command did not restart the breathing ramp.")
   `LPC_ASSERT_NEXT(a_hold_state, clock, reset, !flow.advance,
      $stable(mode_ff) && $stable(elapsed_ff) && $stable(bright_ff),
      "Mode state changed without an accepted word.")
   `LPC_ASSERT_NOW(a_bright_range, clock, reset, mode_ff == MODE_PULSE,
      {1'b0, bright_ff} <= 9'(PULSE_TOP), "Pulse brightness exceeds its top value.")
   `LPC_ASSERT_NOW(a_step_nonzero, clock, reset, 1'b1, blink_step_ff != '0,
      "Blink step counter reached zero.")

endmodule

@@ hw/rtl/lpc_rsp_stage.sv @@
// Result register stage of the LED pattern controller.
module lpc_rsp_stage
   import lpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  flow_type          flow,
   input  rsp_word_type      result,
   output logic              rsp_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DUTY_W-1:0] rsp_duty,
   output logic              rsp_led_on
);

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_word_type result_ff;

   assign rsp_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (flow.advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (flow.advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_duty   = result_ff.duty;
   assign rsp_led_on = result_ff.led_on;

endmodule

@@ test/led_pattern_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts the LED pattern controller's response words and compares them.
module led_pattern_checker
   import lpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [STEP_W-1:0]      req_blink_lit_step,
   input  logic [STEP_W-1:0]      req_blink_cycle_steps,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [DUTY_W-1:0]      rsp_duty,
   input  logic                   rsp_led_on,
   output int                     fail_count,
   output int                     words_pending
);

   mode_type             pat_mode;
   logic [MS_W-1:0]      period_default;
   logic [MS_W-1:0]      period_slow;
   logic [MS_W-1:0]      period_fast;
   logic [MS_W-1:0]      elapsed;
   logic [MS_W-1:0]      period;
   logic [STEP_W-1:0]    step_now;
   logic [STEP_W-1:0]    step_lit;
   logic [STEP_W-1:0]    step_count;
   logic [BRIGHT_W-1:0]  level;
   logic                 falling;
   logic                 pin;
   rsp_word_type         led_queue[$];
   int                   mismatches = 0;
   int                   words_checked = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: word %0d: %s", $time, words_checked, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      logic         run;
      logic         due;
      logic [8:0]   next_step;
      int           bright;
      rsp_word_type want;

      if (reset) begin
         pat_mode       = MODE_OFF;
         period_default = DEFAULT_PERIOD_RST;
         period_slow    = SLOW_PERIOD_RST;
         period_fast    = FAST_PERIOD_RST;
         elapsed        = '0;
         period         = '0;
         step_now       = 8'd1;
         step_lit       = 8'd1;
         step_count     = 8'd1;
         level          = '0;
         falling        = 1'b0;
         pin            = 1'b0;
         led_queue.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_DEFAULT_PERIOD: period_default = csr_data;
               CSR_SLOW_PERIOD:    period_slow = csr_data;
               CSR_FAST_PERIOD:    period_fast = csr_data;
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (led_queue.size() == 0) begin
               report_mismatch($sformatf("response duty %0d led_on %0b with nothing expected",
                                         rsp_duty, rsp_led_on));
            end else begin
               want = led_queue.pop_front();
               if (rsp_duty !== want.duty)
                  report_mismatch($sformatf("duty %0d, expected %0d", rsp_duty, want.duty));
               if (rsp_led_on !== want.led_on)
                  report_mismatch($sformatf("led_on %0b, expected %0b", rsp_led_on,
                                            want.led_on));
            end
            words_checked++;
         end

         if (req_valid && !req_stall) begin
            run = 1'b1;
            case (req_operation)
               OP_TICK: begin
                  if (elapsed != ELAPSED_MAX)
                     elapsed = elapsed + 1'b1;
               end
               OP_ON:  pat_mode = MODE_ON;
               OP_OFF: pat_mode = MODE_OFF;
               OP_FLASH: begin
                  pin      = 1'b1;
                  pat_mode = MODE_FLASH;
                  elapsed  = '0;
                  period   = period_default;
               end
               OP_DIP: begin
                  pin      = 1'b0;
                  pat_mode = MODE_DIP;
                  elapsed  = '0;
                  period   = period_default;
               end
               OP_BLINK: begin
                  step_lit   = req_blink_lit_step;
                  step_count = req_blink_cycle_steps;
                  step_now   = 8'd1;
                  pat_mode   = MODE_BLINK_LIT;
                  period     = period_default;
                  elapsed    = '0;
               end
               OP_PULSE: begin
                  pat_mode = MODE_PULSE;
                  level    = '0;
                  falling  = 1'b0;
                  period   = 16'd1;
                  elapsed  = '0;
                  run      = 1'b0;
               end
               OP_SLOW: begin
                  period = period_slow;
                  run    = 1'b0;
               end
               OP_FAST: begin
                  period = period_fast;
                  run    = 1'b0;
               end
               default: run = 1'b0;
            endcase

            if (run) begin
               due = elapsed > period;
               case (pat_mode)
                  MODE_FLASH: begin
                     if (due) begin
                        pin      = 1'b0;
                        pat_mode = MODE_OFF;
                     end
                  end
                  MODE_DIP: begin
                     if (due) begin
                        pin      = 1'b1;
                        pat_mode = MODE_ON;
                     end
                  end
                  MODE_BLINK_LIT: begin
                     if (step_now == step_lit)
                        pin = 1'b1;
                     if (due) begin
                        pin      = 1'b0;
                        pat_mode = MODE_BLINK_DARK;
                        elapsed  = '0;
                     end
                  end
                  MODE_BLINK_DARK: begin
                     if (due) begin
                        next_step = {1'b0, step_now} + 9'd1;
                        pat_mode  = MODE_BLINK_LIT;
                        elapsed   = '0;
                        step_now  = (next_step > {1'b0, step_count}) ? 8'd1 : next_step[7:0];
                     end
                  end
                  MODE_PULSE: begin
                     if (due) begin
                        elapsed = '0;
                        period  = 16'd1;
                        bright  = int'(level);
                        bright  = falling ? bright - PULSE_INCREMENT_DEF
                                          : bright + PULSE_INCREMENT_DEF;
                        if (bright <= 0) begin
                           period  = MS_W'(PULSE_PAUSE_MS_DEF);
                           bright  = 0;
                           falling = !falling;
                        end else if (bright >= PULSE_TOP_DEF) begin
                           bright  = PULSE_TOP_DEF;
                           falling = !falling;
                        end
                        level = BRIGHT_W'(bright);
                     end
                  end
                  MODE_ON: pin = 1'b1;
                  default: pin = 1'b0;
               endcase
            end

            want.duty   = (pat_mode == MODE_PULSE) ? DUTY_W'(level)
                                                   : (pin ? DUTY_FULL : '0);
            want.led_on = pin;
            led_queue.push_back(want);
         end
      end
      words_pending = led_queue.size();
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Testbench top that drives the LED pattern controller with directed and random words.
module testbench;
   import lpc_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [OP_W-1:0]        req_operation;
   logic [STEP_W-1:0]      req_blink_lit_step;
   logic [STEP_W-1:0]      req_blink_cycle_steps;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [DUTY_W-1:0]      rsp_duty;
   logic                   rsp_led_on;
   int                     fail_count;
   int                     words_pending;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int words_sent = 0;

   led_pattern_controller_top u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_blink_lit_step    (req_blink_lit_step),
      .req_blink_cycle_steps (req_blink_cycle_steps),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_duty              (rsp_duty),
      .rsp_led_on            (rsp_led_on)
   );

   led_pattern_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_blink_lit_step    (req_blink_lit_step),
      .req_blink_cycle_steps (req_blink_cycle_steps),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_duty              (rsp_duty),
      .rsp_led_on            (rsp_led_on),
      .fail_count            (fail_count),
      .words_pending         (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(2_000_000 * 8);
      $display("*** FAILED ***");
      $finish;
   end

   // The receiver stalls at random, or for a fixed stretch when one is requested.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic send_word(input logic [OP_W-1:0] op, input logic [STEP_W-1:0] lit,
                            input logic [STEP_W-1:0] cyc);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid             <= 1'b1;
      req_operation         <= op;
      req_blink_lit_step    <= lit;
      req_blink_cycle_steps <= cyc;
      forever begin
         @(posedge clock);
         if (!req_stall)
            break;
      end
      @(negedge clock);
      if (op <= OP_FAST)
         words_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (words_pending != 0)
         @(negedge clock);
   endtask

   task automatic load_periods(input logic [CSR_DATA_W-1:0] dflt,
                               input logic [CSR_DATA_W-1:0] slow,
                               input logic [CSR_DATA_W-1:0] fast);
      csr_write <= 1'b1;
      csr_index <= CSR_DEFAULT_PERIOD;
      csr_data  <= dflt;
      @(negedge clock);
      csr_index <= CSR_SLOW_PERIOD;
      csr_data  <= slow;
      @(negedge clock);
      csr_index <= CSR_FAST_PERIOD;
      csr_data  <= fast;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Mostly a command followed by a run of ticks, with some noise words mixed in.
   task automatic run_random(input int count);
      int                target;
      int                burst;
      logic [OP_W-1:0]   op;
      logic [STEP_W-1:0] lit;
      logic [STEP_W-1:0] cyc;
      target = words_sent + count;
      while (words_sent < target) begin
         lit   = ($urandom_range(4) == 0) ? STEP_W'($urandom) : STEP_W'($urandom_range(5));
         cyc   = ($urandom_range(4) == 0) ? STEP_W'($urandom) : STEP_W'($urandom_range(5));
         burst = $urandom_range(0, 30);
         case ($urandom_range(11))
            0: begin
               repeat ($urandom_range(1, 3))
                  send_word(OP_W'($urandom_range(15)), STEP_W'($urandom), STEP_W'($urandom));
               continue;
            end
            1: begin
               op    = OP_PULSE;
               burst = ($urandom_range(3) == 0) ? $urandom_range(230, 280)
                                                : $urandom_range(0, 60);
            end
            2: op = OP_ON;
            3: op = OP_OFF;
            4, 5: op = OP_FLASH;
            6, 7: op = OP_DIP;
            8, 9: begin
               op    = OP_BLINK;
               burst = $urandom_range(0, 60);
            end
            default: op = $urandom_range(1) ? OP_SLOW : OP_FAST;
         endcase
         send_word(op, lit, cyc);
         repeat (burst) begin
            if ($urandom_range(19) == 0)
               send_word($urandom_range(1) ? OP_SLOW : OP_FAST, STEP_W'($urandom),
                         STEP_W'($urandom));
            else
               send_word(OP_TICK, STEP_W'($urandom), STEP_W'($urandom));
         end
      end
   endtask

   initial begin
      reset                 = 1'b1;
      csr_write             = 1'b0;
      csr_index             = CSR_DEFAULT_PERIOD;
      csr_data              = '0;
      req_valid             = 1'b0;
      req_operation         = OP_TICK;
      req_blink_lit_step    = '0;
      req_blink_cycle_steps = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset periods: unknown codes, every command, blink edge cases and a pulse start.
      send_word(4'd15, 8'hFF, 8'hFF);
      send_word(4'd9, 8'h00, 8'h00);
      send_word(OP_ON, 8'h00, 8'h00);
      send_word(OP_OFF, 8'h00, 8'h00);
      send_word(OP_FLASH, 8'h00, 8'h00);
      send_word(OP_TICK, 8'h00, 8'h00);
      send_word(OP_FAST, 8'h00, 8'h00);
      send_word(OP_SLOW, 8'h00, 8'h00);
      send_word(OP_DIP, 8'h00, 8'h00);
      send_word(OP_BLINK, 8'd0, 8'd0);
      send_word(OP_BLINK, 8'd255, 8'd1);
      send_word(OP_BLINK, 8'd1, 8'd255);
      send_word(OP_PULSE, 8'h00, 8'h00);
      repeat (4) send_word(OP_TICK, 8'h00, 8'h00);
      drain();

      // A zero period runs out on the first tick.
      load_periods(16'd0, 16'd65535, 16'd0);
      send_word(OP_FLASH, 8'h00, 8'h00);
      send_word(OP_TICK, 8'h00, 8'h00);
      send_word(OP_BLINK, 8'd1, 8'd2);
      repeat (4) send_word(OP_TICK, 8'h00, 8'h00);
      send_word(OP_DIP, 8'h00, 8'h00);
      send_word(OP_TICK, 8'h00, 8'h00);
      drain();

      send_idle_pct = 31;
      recv_idle_pct = 85;
      load_periods(16'd3, 16'd12, 16'd1);
      run_random(400);
      drain();

      send_idle_pct = 85;
      recv_idle_pct = 31;
      load_periods(CSR_DATA_W'($urandom_range(0, 8)), 16'd65535, 16'd0);
      run_random(400);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_periods(CSR_DATA_W'($urandom_range(0, 6)), CSR_DATA_W'($urandom_range(0, 20)),
                   CSR_DATA_W'($urandom_range(0, 3)));
      run_random(50);
      hold_cycles = 300;
      run_random(350);
      drain();

      // Full-scale periods do not run out over a short run of ticks.
      load_periods(16'd65535, 16'd65534, 16'd65535);
      send_word(OP_FLASH, 8'h00, 8'h00);
      repeat (20) send_word(OP_TICK, 8'h00, 8'h00);
      send_word(OP_FAST, 8'h00, 8'h00);
      send_word(OP_TICK, 8'h00, 8'h00);
      send_word(OP_SLOW, 8'h00, 8'h00);
      send_word(OP_TICK, 8'h00, 8'h00);
      drain();

      repeat (8) @(negedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
